/* hw/rtl/page_frame_buffer_glyph_writer_assert.svh */
// ----------------------------------------------------------------------------
// page_frame_buffer_glyph_writer_assert.svh
// Assertion macros for the frame buffer glyph writer.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BUFFER_GLYPH_WRITER_ASSERT_SVH
`define PAGE_FRAME_BUFFER_GLYPH_WRITER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PFBGW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfbgw assertion failed");
// next-cycle implication
`define PFBGW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfbgw assertion failed");
`else
`define PFBGW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFBGW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/pfbgw_pkg.sv */
// ----------------------------------------------------------------------------
// pfbgw_pkg
// Shared types and constants of the frame buffer glyph writer.
// ----------------------------------------------------------------------------
package pfbgw_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_GLYPH = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FONT    = 2'd2;

    localparam logic [4:0] FONT_H_SMALL = 5'd12;
    localparam logic [4:0] FONT_H_MID   = 5'd16;
    localparam logic [4:0] FONT_H_LARGE = 5'd24;

    // Decoded work for one item: up to two read-modify-writes
    typedef struct packed {
        logic       is_read;
        logic       rd_ok;
        logic       wr_a;
        logic       wr_b;
        logic [7:0] mask_a;
        logic [7:0] mask_b;
        logic [7:0] val;
        logic [1:0] status;
    } dec_t;

endpackage

/* hw/rtl/pfbgw_ram.sv */
// ----------------------------------------------------------------------------
// pfbgw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfbgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/pfbgw_decode.sv */
// ----------------------------------------------------------------------------
// pfbgw_decode
// Turns one item into buffer addresses, bit masks and a status code.
// ----------------------------------------------------------------------------
module pfbgw_decode
    import pfbgw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  op_t                                op,
    input  logic [6:0]                         column,
    input  logic [5:0]                         row,
    input  logic [1:0]                         byte_index,
    input  logic [4:0]                         font_height,
    input  logic                               inverse,
    input  logic [7:0]                         glyph_byte,
    output dec_t                               dec,
    output logic [$clog2(COLUMNS*PAGES)-1:0]   addr_a,
    output logic [$clog2(COLUMNS*PAGES)-1:0]   addr_b
);

    localparam int         ADDR_W   = $clog2(COLUMNS * PAGES);
    localparam logic [8:0] COL_LIM  = 9'(COLUMNS);
    localparam logic [4:0] PAGE_LIM = 5'(PAGES);

    logic [1:0] k_eff;
    logic [6:0] row0;
    logic [3:0] page_a;
    logic [3:0] page_b;
    logic [2:0] bit0;
    logic [4:0] base;
    logic [4:0] diff;
    logic [3:0] n_rows;
    logic       col_ok;
    logic       pa_ok;
    logic       pb_ok;
    logic       fh_ok;
    logic [7:0] gmask_a;
    logic [7:0] gmask_b;
    logic [7:0] gval;

    assign k_eff  = (op == OP_GLYPH) ? byte_index : 2'd0;
    assign row0   = {1'b0, row} + {2'b00, k_eff, 3'b000};
    assign page_a = row0[6:3];
    assign page_b = page_a + 4'd1;
    assign bit0   = row0[2:0];
    assign base   = {k_eff, 3'b000};
    assign diff   = font_height - base;
    assign col_ok = {2'b00, column} < COL_LIM;
    assign pa_ok  = {1'b0, page_a} < PAGE_LIM;
    assign pb_ok  = {1'b0, page_b} < PAGE_LIM;
    assign fh_ok  = (font_height == FONT_H_SMALL) || (font_height == FONT_H_MID) ||
                    (font_height == FONT_H_LARGE);

    // rows left in this glyph byte, at most eight
    always_comb
    begin
        if (font_height <= base)
        begin
            n_rows = 4'd0;
        end
        else if (diff[4:3] != 2'b00)
        begin
            n_rows = 4'd8;
        end
        else
        begin
            n_rows = {1'b0, diff[2:0]};
        end
    end

    // Bit i of either page takes glyph row (i - bit0) mod 8, MSB first
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            logic [2:0] j;
            j          = 3'(i) - bit0;
            gval[i]    = glyph_byte[~j] ^ inverse;
            gmask_a[i] = (3'(i) >= bit0) && ({1'b0, j} < n_rows);
            gmask_b[i] = (3'(i) < bit0) && ({1'b0, j} < n_rows);
        end
    end

    always_comb
    begin
        dec = '0;
        unique case (op)
            OP_SET, OP_CLEAR:
            begin
                dec.mask_a = 8'h01 << bit0;
                dec.val    = (op == OP_SET) ? 8'hFF : 8'h00;
                dec.wr_a   = col_ok && pa_ok;
                dec.status = (col_ok && pa_ok) ? ST_OK : ST_OUTSIDE;
            end
            OP_GLYPH:
            begin
                dec.mask_a = gmask_a;
                dec.mask_b = gmask_b;
                dec.val    = gval;
                if (!fh_ok)
                begin
                    dec.status = ST_FONT;
                end
                else
                begin
                    dec.wr_a = (|gmask_a) && col_ok && pa_ok;
                    dec.wr_b = (|gmask_b) && col_ok && pb_ok;
                    if (((|gmask_a) && !(col_ok && pa_ok)) ||
                        ((|gmask_b) && !(col_ok && pb_ok)))
                    begin
                        dec.status = ST_OUTSIDE;
                    end
                end
            end
            OP_READ:
            begin
                dec.is_read = 1'b1;
                dec.rd_ok   = col_ok && pa_ok;
                dec.status  = (col_ok && pa_ok) ? ST_OK : ST_OUTSIDE;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

    // only meaningful when the page is in range
    assign addr_a = ADDR_W'(32'(page_a) * COLUMNS + 32'(column));
    assign addr_b = ADDR_W'(32'(page_b) * COLUMNS + 32'(column));

endmodule

/* hw/rtl/page_frame_buffer_glyph_writer.sv */
// The page A read is issued as the input word is taken; S_MOD_A writes page
// A back, S_MOD_B writes page B when a glyph byte straddles two pages, and
// the result is then registered, or parked in S_HOLD while the output is busy.
// A new item is taken only once the last is through its read-then-write on
// the single frame buffer read port. Reset: clears all COLUMNS*PAGES entries
// (1024 by default) with s_tready low; no items are taken until the sweep ends.
// ----------------------------------------------------------------------------
// page_frame_buffer_glyph_writer
// Page-organized monochrome frame buffer with pixel, glyph byte and refresh
// read operations, built around one synchronous buffer memory.
// ----------------------------------------------------------------------------
`include "page_frame_buffer_glyph_writer_assert.svh"

module page_frame_buffer_glyph_writer
    import pfbgw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // column[6:0], row[12:7], byte_index[14:13], font_height[19:15],
    // inverse[20], glyph_byte[28:21], zero fill [31:29]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data[7:0], status[9:8], zero fill [15:10]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD_A,
        S_MOD_B,
        S_HOLD
    } state_t;

    state_t               state_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    dec_t                 dec_reg;
    logic [ADDR_W-1:0]    addr_a_reg;
    logic [ADDR_W-1:0]    addr_b_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] hold_tdata_reg;

    dec_t                 dec_in;
    logic [ADDR_W-1:0]    addr_a_in;
    logic [ADDR_W-1:0]    addr_b_in;

    logic                 s_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [7:0]           mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [7:0]           mem_rdata;
    logic [7:0]           res_data;
    logic [M_TDATA_W-1:0] res_tdata;

    pfbgw_decode #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_decode (
        .op          (op_t'(s_tuser[1:0])),
        .column      (s_tdata[6:0]),
        .row         (s_tdata[12:7]),
        .byte_index  (s_tdata[14:13]),
        .font_height (s_tdata[19:15]),
        .inverse     (s_tdata[20]),
        .glyph_byte  (s_tdata[28:21]),
        .dec         (dec_in),
        .addr_a      (addr_a_in),
        .addr_b      (addr_b_in)
    );

    pfbgw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_buffer (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Load a result word into the output register this cycle
    assign out_load = ((((state_reg == S_MOD_A) && !dec_reg.wr_b) ||
                        (state_reg == S_MOD_B)) && out_free) ||
                      ((state_reg == S_HOLD) && m_tready);

    // Memory port steering. Every read is issued after the previous item's
    // writes have landed, and the page B read in S_MOD_A targets a different
    // entry from the page A write in the same cycle, so no forwarding is needed.
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = addr_a_in;
        mem_we    = 1'b0;
        mem_waddr = addr_a_reg;
        mem_wdata = (mem_rdata & ~dec_reg.mask_a) | (dec_reg.val & dec_reg.mask_a);
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 8'h00;
            end
            S_IDLE:
            begin
                mem_re = s_accept;
            end
            S_MOD_A:
            begin
                // write back page A, fetch page B when the byte straddles
                mem_we    = dec_reg.wr_a;
                mem_re    = dec_reg.wr_b;
                mem_raddr = addr_b_reg;
            end
            S_MOD_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b_reg;
                mem_wdata = (mem_rdata & ~dec_reg.mask_b) | (dec_reg.val & dec_reg.mask_b);
            end
            S_HOLD:
            begin
                mem_re = 1'b0;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Result word: buffer byte only for an in-range read
    assign res_data  = (dec_reg.is_read && dec_reg.rd_ok) ? mem_rdata : 8'h00;
    assign res_tdata = {6'b000000, dec_reg.status, res_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            dec_reg        <= '0;
            addr_a_reg     <= '0;
            addr_b_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            hold_tdata_reg <= '0;
        end
        else
        begin
            // raise on a new result, drop once the word is taken
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    // sweep the buffer to zero, one entry per cycle
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        dec_reg    <= dec_in;
                        addr_a_reg <= addr_a_in;
                        addr_b_reg <= addr_b_in;
                        state_reg  <= S_MOD_A;
                    end
                end
                S_MOD_A, S_MOD_B:
                begin
                    if ((state_reg == S_MOD_A) && dec_reg.wr_b)
                    begin
                        state_reg <= S_MOD_B;
                    end
                    else if (out_free)
                    begin
                        m_tdata_reg <= res_tdata;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        // output still busy: park the result
                        hold_tdata_reg <= res_tdata;
                        state_reg      <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (m_tready)
                    begin
                        m_tdata_reg <= hold_tdata_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A taken word always starts the page A read-modify-write
    `PFBGW_ASSERT_NXT(a_accept_to_mod, clk, rst_n, s_accept, state_reg == S_MOD_A)
    // The second page write never lands on the first page's entry
    `PFBGW_ASSERT_IMP(a_page_b_distinct, clk, rst_n, state_reg == S_MOD_B,
        mem_we && (mem_waddr != addr_a_reg))
    // Unsupported font height leaves the buffer untouched
    `PFBGW_ASSERT_IMP(a_font_no_write, clk, rst_n,
        (state_reg == S_MOD_A) && (dec_reg.status == ST_FONT), !mem_we && !mem_re)
    // Nonzero read data only comes with an ok status
    `PFBGW_ASSERT_IMP(a_data_status, clk, rst_n,
        m_tvalid_reg && (m_tdata_reg[7:0] != 8'h00), m_tdata_reg[9:8] == ST_OK)

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page frame buffer glyph writer. A shadow copy
// of the buffer predicts the reply word of every accepted command word, and
// each reply is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import pfbgw_pkg::*;
();

    // One command word as the bench sees it, before packing
    typedef struct {
        op_t        op;
        logic [6:0] column;
        logic [5:0] row;
        logic [1:0] byte_index;
        logic [4:0] font_height;
        logic       inverse;
        logic [7:0] glyph_byte;
    } draw_cmd_t;

    // One predicted reply word
    typedef struct {
        logic [7:0] read_data;
        logic [1:0] status;
    } reply_t;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BUF_BYTES       = COLUMNS_DEF * PAGES_DEF;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // column[6:0], row[12:7], byte_index[14:13], font_height[19:15],
    // inverse[20], glyph_byte[28:21], zero fill [31:29]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // op[1:0]
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // read_data[7:0], status[9:8], zero fill [15:10]
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow of the frame buffer; bit arrays start out all zero like the block
    bit [7:0]  shadow_fb [0:BUF_BYTES-1];

    draw_cmd_t pending_cmds [$];
    reply_t    replies_due  [$];
    draw_cmd_t offered_cmd;
    bit        offer_live     = 1'b0;
    int        send_gap       = 0;
    int        hold_left      = 0;
    bit        sender_quiet   = 1'b0;
    bit        receiver_quiet = 1'b0;
    bit        pressure_req   = 1'b0;

    int        fail_count  = 0;
    int        n_queued    = 0;
    int        n_replies   = 0;
    int        op_count [4];
    int        st_count [3];

    page_frame_buffer_glyph_writer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow buffer and reply prediction
    // ------------------------------------------------------------------

    // Write one pixel of the shadow; report whether it landed in the buffer
    function automatic bit shadow_put(int x, int y, bit lit);
        int page;
        page = y >> 3;
        if (x >= COLUMNS_DEF || page >= PAGES_DEF)
            return 1'b0;
        shadow_fb[page * COLUMNS_DEF + x][y & 7] = lit;
        return 1'b1;
    endfunction

    // Apply one command word to the shadow and return the reply it earns
    function automatic reply_t apply_frame_op(draw_cmd_t c);
        reply_t r;
        int     off;
        int     page;
        bit     lit;
        r.read_data = 8'h00;
        r.status    = ST_OK;
        case (c.op)
            OP_SET, OP_CLEAR:
            begin
                if (!shadow_put(c.column, c.row, c.op == OP_SET))
                    r.status = ST_OUTSIDE;
            end
            OP_GLYPH:
            begin
                if (c.font_height != FONT_H_SMALL && c.font_height != FONT_H_MID &&
                    c.font_height != FONT_H_LARGE)
                begin
                    // bad height wins over any outside pixel and writes nothing
                    r.status = ST_FONT;
                end
                else
                begin
                    // MSB is the topmost row; stop once the glyph height is reached
                    for (int j = 0; j < 8; j++)
                    begin
                        off = 8 * c.byte_index + j;
                        if (off < c.font_height)
                        begin
                            lit = c.glyph_byte[7 - j] ^ c.inverse;
                            if (!shadow_put(c.column, c.row + off, lit))
                                r.status = ST_OUTSIDE;
                        end
                    end
                end
            end
            default:
            begin
                page = c.row >> 3;
                if (c.column >= COLUMNS_DEF || page >= PAGES_DEF)
                    r.status = ST_OUTSIDE;
                else
                    r.read_data = shadow_fb[page * COLUMNS_DEF + c.column];
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic draw_cmd_t make_cmd(op_t op, int col, int row, int k, int fh,
                                           bit inv, int gb);
        draw_cmd_t c;
        c.op          = op;
        c.column      = col[6:0];
        c.row         = row[5:0];
        c.byte_index  = k[1:0];
        c.font_height = fh[4:0];
        c.inverse     = inv;
        c.glyph_byte  = gb[7:0];
        return c;
    endfunction

    // Every field random over its full width
    function automatic draw_cmd_t noise_cmd();
        return make_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 127),
                        $urandom_range(0, 63), $urandom_range(0, 3),
                        $urandom_range(0, 31), $urandom_range(0, 1),
                        $urandom_range(0, 255));
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_cmd(draw_cmd_t c);
        pending_cmds.push_back(c);
        n_queued++;
    endtask

    // Set/clear/read with junk in the fields those ops ignore
    task automatic queue_plain(op_t op, int col, int row);
        draw_cmd_t c;
        c    = noise_cmd();
        c.op = op;
        c.column = col[6:0];
        c.row    = row[5:0];
        queue_cmd(c);
    endtask

    // A whole glyph column, top byte first, then read back the pages it hit
    task automatic queue_glyph_column();
        int col;
        int row;
        int fh;
        int nbytes;
        bit inv;
        col = $urandom_range(0, 127);
        case ($urandom_range(0, 2))
            0:       fh = FONT_H_SMALL;
            1:       fh = FONT_H_MID;
            default: fh = FONT_H_LARGE;
        endcase
        // mostly keep the glyph inside the buffer, sometimes let it run off
        if ($urandom_range(0, 9) < 7)
            row = $urandom_range(0, 64 - fh);
        else
            row = $urandom_range(0, 63);
        nbytes = (fh + 7) / 8;
        // occasionally a bad height, occasionally a byte past the glyph
        if ($urandom_range(0, 9) == 0)
            fh = $urandom_range(0, 31);
        if ($urandom_range(0, 6) == 0 && nbytes < 4)
            nbytes++;
        inv = $urandom_range(0, 1);
        for (int k = 0; k < nbytes; k++)
            queue_cmd(make_cmd(OP_GLYPH, col, row, k, fh, inv, $urandom_range(0, 255)));
        for (int p = 0; p <= nbytes; p++)
            if (row + 8 * p < 64)
                queue_plain(OP_READ, col, row + 8 * p);
    endtask

    task automatic queue_random(int count);
        int target;
        int pick;
        target = n_queued + count;
        while (n_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_glyph_column();
            else if (pick < 60)
                queue_plain($urandom_range(0, 1) ? OP_SET : OP_CLEAR,
                            $urandom_range(0, 127), $urandom_range(0, 63));
            else if (pick < 85)
                queue_plain(OP_READ, $urandom_range(0, 127), $urandom_range(0, 63));
            else
                queue_cmd(noise_cmd());
        end
    endtask

    // Hold until every queued word has gone in and every reply has come back
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || offer_live || replies_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n || offer_live)
        begin
            // hold the current word until it is taken
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            s_tvalid <= 1'b0;
        end
        else if (pending_cmds.size() != 0)
        begin
            offered_cmd = pending_cmds.pop_front();
            s_tdata  <= {3'b000, offered_cmd.glyph_byte, offered_cmd.inverse,
                         offered_cmd.font_height, offered_cmd.byte_index,
                         offered_cmd.row, offered_cmd.column};
            s_tuser  <= offered_cmd.op;
            s_tvalid <= 1'b1;
            offer_live = 1'b1;
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Input handshake: predict the reply of every accepted word
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            replies_due.push_back(apply_frame_op(offered_cmd));
            op_count[offered_cmd.op]++;
            offer_live = 1'b0;
            if (sender_quiet || $urandom_range(0, 1) == 0)
                send_gap = 0;
            else
                send_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (pressure_req)
        begin
            // long hold-off: let the block back up and drop s_tready
            pressure_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (receiver_quiet || $urandom_range(0, 9) < 7)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            hold_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end
    end

    // Output handshake: compare each reply with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_replies++;
            if (m_tdata[9:8] <= ST_FONT)
                st_count[m_tdata[9:8]]++;
            if (replies_due.size() == 0)
            begin
                $error("reply word with no command pending: tdata %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                reply_t want;
                want = replies_due.pop_front();
                if (m_tdata[7:0] !== want.read_data)
                begin
                    $error("read_data mismatch: expected %0h, actual %0h",
                           want.read_data, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[9:8] !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_tdata[9:8]);
                    fail_count++;
                end
                if (m_tdata[M_TDATA_W-1:10] !== '0)
                begin
                    $error("zero fill mismatch: expected 0, actual %0h",
                           m_tdata[M_TDATA_W-1:10]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: corners of the pixel space, readback after clear
        queue_plain(OP_SET, 0, 0);
        queue_plain(OP_SET, 127, 63);
        queue_plain(OP_READ, 0, 0);
        queue_plain(OP_READ, 127, 63);
        queue_plain(OP_CLEAR, 0, 0);
        queue_plain(OP_READ, 0, 0);
        // glyph bytes of a 12-row font, the second one cut short at row 12
        queue_cmd(make_cmd(OP_GLYPH, 10, 0, 0, FONT_H_SMALL, 1'b0, 8'hA5));
        queue_cmd(make_cmd(OP_GLYPH, 10, 0, 1, FONT_H_SMALL, 1'b0, 8'hFF));
        queue_plain(OP_READ, 10, 0);
        queue_plain(OP_READ, 10, 8);
        // inverted byte straddling pages 1 and 2
        queue_cmd(make_cmd(OP_GLYPH, 20, 3, 1, FONT_H_MID, 1'b1, 8'h3C));
        queue_plain(OP_READ, 20, 8);
        queue_plain(OP_READ, 20, 16);
        // unsupported heights, one of them also off the bottom of the buffer
        queue_cmd(make_cmd(OP_GLYPH, 30, 8, 0, 13, 1'b0, 8'hFF));
        queue_cmd(make_cmd(OP_GLYPH, 30, 8, 0, 0, 1'b1, 8'hFF));
        queue_cmd(make_cmd(OP_GLYPH, 30, 60, 2, 31, 1'b0, 8'hFF));
        // bytes past the end of the glyph write nothing
        queue_cmd(make_cmd(OP_GLYPH, 40, 0, 2, FONT_H_MID, 1'b0, 8'hFF));
        queue_cmd(make_cmd(OP_GLYPH, 40, 0, 3, FONT_H_LARGE, 1'b1, 8'h00));
        // glyph rows entirely below, partly below and at the bottom edge of the buffer
        queue_cmd(make_cmd(OP_GLYPH, 127, 60, 2, FONT_H_LARGE, 1'b0, 8'hFF));
        queue_cmd(make_cmd(OP_GLYPH, 50, 58, 0, FONT_H_MID, 1'b0, 8'hFF));
        queue_plain(OP_READ, 50, 56);
        queue_cmd(make_cmd(OP_GLYPH, 60, 40, 2, FONT_H_LARGE, 1'b0, 8'h81));
        queue_plain(OP_READ, 60, 56);
        wait_drained();

        // Back-to-back offers while the receiver holds off for a long stretch
        sender_quiet = 1'b1;
        pressure_req = 1'b1;
        queue_random(120);
        wait_drained();

        // Random gaps on both sides
        sender_quiet = 1'b0;
        queue_random(280);
        wait_drained();

        // Full rate, no idling anywhere
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
        queue_random(150);
        wait_drained();

        // let any stray reply word show up before the verdict
        repeat (20) @(posedge clk);

        $display("Covered %0d command words: %0d set, %0d clear, %0d glyph, %0d read",
                 n_queued, op_count[OP_SET], op_count[OP_CLEAR], op_count[OP_GLYPH],
                 op_count[OP_READ]);
        $display("Checked %0d replies: %0d ok, %0d outside buffer, %0d bad font height",
                 n_replies, st_count[ST_OK], st_count[ST_OUTSIDE], st_count[ST_FONT]);
        if (fail_count == 0)
            $display("page_frame_buffer_glyph_writer test passed");
        else
            $display("page_frame_buffer_glyph_writer test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the reset sweep
    initial
    begin
        #5_000_000;
        $display("page_frame_buffer_glyph_writer test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pfbgw_pkg.sv
hw/rtl/pfbgw_ram.sv
hw/rtl/pfbgw_decode.sv
hw/rtl/page_frame_buffer_glyph_writer.sv
sim/tb_top.sv
